// File: rtl/vad_frame_label_smoother_unit_assert.svh
// Assertion macros shared by the frame label smoother RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef VAD_FRAME_LABEL_SMOOTHER_UNIT_ASSERT_SVH
`define VAD_FRAME_LABEL_SMOOTHER_UNIT_ASSERT_SVH

// Condition holds at every clock edge.
`define VFLS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define VFLS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vfls_pkg.sv
// Package for the frame label smoother: widths, codes and shared types.
// No dependencies; every other file except the assertion macro header imports it.
package vfls_pkg;

    localparam int HOLD_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF   = 16;

    localparam int MODE_W     = 2;
    localparam int LM_W       = 5;
    localparam int MS_W       = 6;
    localparam int RM_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME     = 2'd0,
        MODE_FLUSH     = 2'd1,
        MODE_FLUSH_SIL = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAD_FRAMES = 2'd0,
        CFG_BURST_MIN   = 2'd1,
        CFG_HANG_FRAMES = 2'd2
    } t_cfg_idx;

    // how many held frames stay in the store after an item
    typedef enum logic [1:0] {
        KEEP_ZERO   = 2'd0,
        KEEP_ONE    = 2'd1,
        KEEP_MARGIN = 2'd2,
        KEEP_CAP    = 2'd3
    } t_keep;

    typedef struct packed {
        logic  hold;
        logic  label;
        t_keep keep;
    } t_plan;

endpackage

// File: rtl/vfls_in_if.sv
// Input channel of the frame label smoother: valid/ready plus one frame beat.
// Depends on vfls_pkg.
interface vfls_in_if import vfls_pkg::*; #(
    parameter int TAG_BITS = TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [TAG_BITS-1:0] frame_tag;
    logic                is_speech;

    modport source (output valid, mode, frame_tag, is_speech, input ready);
    modport sink   (input valid, mode, frame_tag, is_speech, output ready);
endinterface

// File: rtl/vfls_out_if.sv
// Output channel of the frame label smoother: valid/ready plus one result beat.
// Depends on vfls_pkg.
interface vfls_out_if import vfls_pkg::*; #(
    parameter int TAG_BITS = TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [TAG_BITS-1:0] out_frame_tag;
    logic                out_is_speech;
    logic                last;

    modport source (output valid, out_frame_tag, out_is_speech, last, input ready);
    modport sink   (input valid, out_frame_tag, out_is_speech, last, output ready);
endinterface

// File: rtl/vad_frame_label_smoother_unit.sv
// Top level of the voice-activity frame label smoother.
// Depends on vfls_pkg, vfls_in_if, vfls_out_if, vfls_phase and vfls_drain.
//
// Takes frame beats (tag + raw speech/silence label) and releases the frame tags
// in input order with a smoothed label, holding them in a FIFO store of
// HOLD_DEPTH entries until their label is settled. An input beat is taken when
// valid and ready are both high; the frames it releases are then read from the
// store one per cycle through its single read port while the output buffer
// has room, so a beat that releases n frames keeps the input side busy until
// the last of them has been read (one beat releases up to HOLD_DEPTH results),
// while a beat that releases nothing leaves it free; output stalls hold back
// the reads. A two-entry output buffer separates the store read from the
// output handshake, so a new input beat is taken while released frames wait.
// `last` marks the final result of each input beat; a beat that releases
// nothing produces no result. Registers (left margin, minimum speech length,
// right margin) are written through the i_cfg_* port at indices 0, 1, 2 and
// must only change while the block is idle. The store has no reset sweep.
module vad_frame_label_smoother_unit import vfls_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vfls_in_if.sink               i_in,
    vfls_out_if.source            o_out
);
    logic [LM_W-1:0] r_lead_frames;
    logic [MS_W-1:0] r_burst_min;
    logic [RM_W-1:0] r_hang_frames;

    logic  in_ready;
    logic  accept;
    t_plan plan;

    // configuration registers, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_frames <= '0;
            r_burst_min   <= '0;
            r_hang_frames <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEAD_FRAMES: r_lead_frames <= i_cfg_data[LM_W-1:0];
                CFG_BURST_MIN:   r_burst_min   <= i_cfg_data[MS_W-1:0];
                CFG_HANG_FRAMES: r_hang_frames <= i_cfg_data[RM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    // phase decision for the beat at the input
    vfls_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_in.mode),
        .i_is_speech   (i_in.is_speech),
        .i_burst_min   (r_burst_min),
        .i_hang_frames (r_hang_frames),
        .o_plan        (plan)
    );

    // store, release sequencer and output buffer
    vfls_drain #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_plan        (plan),
        .i_tag         (i_in.frame_tag),
        .i_lead_frames (r_lead_frames),
        .o_in_ready    (in_ready),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_tag         (o_out.out_frame_tag),
        .o_label       (o_out.out_is_speech),
        .o_last        (o_out.last)
    );
endmodule

// File: rtl/vfls_hold_ram.sv
// Hold store: one write port, one read port, registered read data.
// Depends on vfls_pkg.
module vfls_hold_ram import vfls_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_waddr,
    input  logic [TAG_BITS-1:0]           i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_raddr,
    output logic [TAG_BITS-1:0]           o_rdata
);
    logic [TAG_BITS-1:0] r_mem [HOLD_DEPTH];
    logic [TAG_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/vfls_phase.sv
// Phase machine: silence, minimum-speech check, speech, speech end.
// Turns each beat into a store plan. Depends on vfls_pkg.
module vfls_phase import vfls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_is_speech,
    input  logic [MS_W-1:0]   i_burst_min,
    input  logic [RM_W-1:0]   i_hang_frames,
    output t_plan             o_plan
);
    typedef enum logic [3:0] {
        PH_SIL    = 4'b0001,
        PH_MIN    = 4'b0010,
        PH_SPEECH = 4'b0100,
        PH_END    = 4'b1000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [MS_W-1:0]   r_burst, n_burst;
    logic [RM_W-1:0]   r_trail, n_trail;
    t_plan             plan;

    always_comb begin
        logic [MS_W-1:0] burst_inc;
        logic [RM_W-1:0] trail_base;
        logic [RM_W-1:0] trail_inc;
        logic            min_le_one;

        burst_inc  = (r_burst == '1) ? r_burst : r_burst + 1'b1;
        trail_base = (r_phase == PH_SPEECH) ? '0 : r_trail;
        trail_inc  = (trail_base == '1) ? trail_base : trail_base + 1'b1;
        min_le_one = (i_burst_min <= MS_W'(1));

        n_phase    = r_phase;
        n_burst    = r_burst;
        n_trail    = r_trail;
        plan.hold  = 1'b0;
        plan.label = 1'b0;
        plan.keep  = KEEP_CAP;

        case (t_mode'(i_mode)) inside
            MODE_FRAME: begin
                plan.hold = 1'b1;
                unique case (r_phase)
                    PH_SIL: begin
                        if (!i_is_speech) begin
                            plan.keep = KEEP_MARGIN;
                        end else begin
                            if (i_burst_min != '0) begin
                                n_burst = MS_W'(1);
                            end
                            if (min_le_one) begin
                                plan.keep  = KEEP_ZERO;
                                plan.label = 1'b1;
                                n_phase    = PH_SPEECH;
                            end else begin
                                n_phase    = PH_MIN;
                            end
                        end
                    end
                    PH_MIN: begin
                        if (!i_is_speech) begin
                            plan.keep = KEEP_MARGIN;
                            n_phase   = PH_SIL;
                        end else begin
                            n_burst = burst_inc;
                            if (burst_inc >= i_burst_min) begin
                                plan.keep  = KEEP_ZERO;
                                plan.label = 1'b1;
                                n_phase    = PH_SPEECH;
                            end
                        end
                    end
                    PH_SPEECH, PH_END: begin
                        if (!i_is_speech) begin
                            plan.keep = KEEP_ZERO;
                            n_trail   = trail_base;
                            if (i_hang_frames == '0) begin
                                n_phase = PH_SIL;
                            end else begin
                                // hangover: silent frame goes out as speech
                                plan.label = 1'b1;
                                n_trail    = trail_inc;
                                n_phase    = (trail_inc >= i_hang_frames) ? PH_SIL : PH_END;
                            end
                        end else if (r_phase == PH_SPEECH) begin
                            plan.keep  = KEEP_ZERO;
                            plan.label = 1'b1;
                        end else begin
                            // new burst after hangover, always rechecked
                            plan.label = 1'b1;
                            n_burst    = MS_W'(1);
                            if (min_le_one) begin
                                plan.keep = KEEP_ZERO;
                                n_phase   = PH_SPEECH;
                            end else begin
                                plan.keep = KEEP_ONE;
                                n_phase   = PH_MIN;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SIL;
                    end
                endcase
            end
            MODE_FLUSH, MODE_FLUSH_SIL: begin
                plan.keep  = KEEP_ZERO;
                plan.label = (r_phase == PH_SPEECH) || (r_phase == PH_END);
                if (t_mode'(i_mode) == MODE_FLUSH_SIL) begin
                    n_phase = PH_SIL;
                    n_burst = '0;
                    n_trail = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIL;
            r_burst <= '0;
            r_trail <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_burst <= n_burst;
            r_trail <= n_trail;
        end
    end

    assign o_plan = plan;
endmodule

// File: rtl/vfls_drain.sv
// Hold-store control: FIFO pointers, release sequencer and two-entry output buffer.
// Depends on vfls_pkg, vfls_hold_ram and the assertion macro header.
`include "vad_frame_label_smoother_unit_assert.svh"

module vfls_drain import vfls_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_plan               i_plan,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic [LM_W-1:0]     i_lead_frames,
    output logic                o_in_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_label,
    output logic                o_last
);
    localparam int PTR_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > LM_W) ? CNT_W : LM_W;

    logic [PTR_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_left;
    logic                r_label;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic                r_rd_label;
    logic [TAG_BITS-1:0] r_ob_tag [2];
    logic [1:0]          r_ob_label;
    logic [1:0]          r_ob_last;
    logic                r_ob_wp;
    logic                r_ob_rp;
    logic [1:0]          r_ob_cnt;

    logic [CNT_W-1:0]    keep_val;
    logic [CNT_W-1:0]    cnt_after;
    logic [CNT_W-1:0]    rel_n;
    logic [PTR_W-1:0]    tail;
    logic [PTR_W-1:0]    head_inc;
    logic [TAG_BITS-1:0] rdata;
    logic                pop;
    logic                iss;
    logic [1:0]          ob_next;

    // left margin clipped to the store capacity minus one
    always_comb begin
        logic [CMP_W-1:0] lm_ext;
        logic [CMP_W-1:0] cap;
        logic [CNT_W-1:0] margin;

        lm_ext = CMP_W'(i_lead_frames);
        cap    = CMP_W'(HOLD_DEPTH - 1);
        margin = (lm_ext > cap) ? cap[CNT_W-1:0] : lm_ext[CNT_W-1:0];
        case (i_plan.keep)
            KEEP_ZERO:   keep_val = '0;
            KEEP_ONE:    keep_val = CNT_W'(1);
            KEEP_MARGIN: keep_val = margin;
            default:     keep_val = CNT_W'(HOLD_DEPTH - 1);
        endcase
    end

    always_comb begin
        logic [SUM_W-1:0] sum;

        sum       = SUM_W'(r_head) + SUM_W'(r_count);
        tail      = (sum >= SUM_W'(HOLD_DEPTH)) ? PTR_W'(sum - SUM_W'(HOLD_DEPTH))
                                                : sum[PTR_W-1:0];
        cnt_after = r_count + CNT_W'(i_plan.hold);
        rel_n     = (cnt_after > keep_val) ? cnt_after - keep_val : '0;
        head_inc  = (r_head == PTR_W'(HOLD_DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    assign o_valid    = (r_ob_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign ob_next    = r_ob_cnt + 2'(r_rd_vld) - 2'(pop);
    assign iss        = (r_left != '0) && (ob_next <= 2'd1);
    assign o_in_ready = (r_left == '0) && !r_rd_vld;

    vfls_hold_ram #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept && i_plan.hold),
        .i_waddr (tail),
        .i_wdata (i_tag),
        .i_re    (iss),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_ob_cnt <= 2'd0;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
        end else begin
            r_rd_vld <= iss;
            r_ob_cnt <= ob_next;
            if (r_rd_vld) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            if (i_accept) begin
                r_count <= cnt_after;
                r_left  <= rel_n;
            end else if (iss) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
                r_left  <= r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_label <= i_plan.label;
        end
        if (iss) begin
            r_rd_last  <= (r_left == CNT_W'(1));
            r_rd_label <= r_label;
        end
        if (r_rd_vld) begin
            r_ob_tag[r_ob_wp]   <= rdata;
            r_ob_label[r_ob_wp] <= r_rd_label;
            r_ob_last[r_ob_wp]  <= r_rd_last;
        end
    end

    assign o_tag   = r_ob_tag[r_ob_rp];
    assign o_label = r_ob_label[r_ob_rp];
    assign o_last  = r_ob_last[r_ob_rp];

    `VFLS_ASSERT_IMPL(a_ob_no_overflow, r_rd_vld, (r_ob_cnt != 2'd2) || pop, "ob overflow")
    `VFLS_ASSERT_IMPL(a_count_cap, o_in_ready, r_count <= CNT_W'(HOLD_DEPTH - 1), "store full")
    `VFLS_ASSERT(a_left_le_count, r_left <= r_count, "release count exceeds held count")
    `VFLS_ASSERT_NEXT(a_last_tagged, iss && (r_left == CNT_W'(1)), r_rd_vld && r_rd_last, "no last")
endmodule

// File: tb/tb_vad_frame_label_smoother_unit.sv
// Self-checking testbench for vad_frame_label_smoother_unit: directed and random frame
// beats against an in-bench label predictor, with random idling on both channels.
// Depends on vfls_pkg, vfls_in_if, vfls_out_if and the smoother RTL.
module tb_vad_frame_label_smoother_unit;
    import vfls_pkg::*;

    localparam int TAG_W       = TAG_BITS_DEF;
    localparam int DEPTH       = HOLD_DEPTH_DEF;
    // settle margin for a beat that releases the full store
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT   = 10000000;
    // mode code with no meaning; the block must drop it silently
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        ST_SILENCE,
        ST_ONSET_CHECK,
        ST_SPEECH,
        ST_HANGOVER
    } t_vad_state;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             speech;
        logic             last;
    } t_frame_result;

    // ------------------------------------------------------------------------
    // Label predictor and result checker. note_beat() runs the smoothing
    // machine on every accepted input beat and queues the frames it releases;
    // check_result() pops the oldest one per output beat.
    // ------------------------------------------------------------------------
    class label_scoreboard;
        logic [LM_W-1:0]  lead_frames;
        logic [MS_W-1:0]  burst_min;
        logic [RM_W-1:0]  hang_frames;
        t_vad_state       state;
        int unsigned      burst_len;
        int unsigned      trail_len;
        logic [TAG_W-1:0] store [DEPTH];
        int unsigned      head;
        int unsigned      fill;
        t_frame_result    expected_q [$];
        t_frame_result    beat_q [$];
        int unsigned      mismatches;
        int unsigned      results_seen;
        int unsigned      speech_out;
        int unsigned      beats_noted;
        int unsigned      ignored;

        function new();
            lead_frames  = '0;
            burst_min    = '0;
            hang_frames  = '0;
            state        = ST_SILENCE;
            burst_len    = 0;
            trail_len    = 0;
            head         = 0;
            fill         = 0;
            mismatches   = 0;
            results_seen = 0;
            speech_out   = 0;
            beats_noted  = 0;
            ignored      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LEAD_FRAMES: lead_frames = data[LM_W-1:0];
                CFG_BURST_MIN:   burst_min   = data[MS_W-1:0];
                CFG_HANG_FRAMES: hang_frames = data[RM_W-1:0];
                default: ;
            endcase
        endfunction

        function void release_frame(logic [TAG_W-1:0] tag, logic speech);
            t_frame_result r;
            r.tag    = tag;
            r.speech = speech;
            r.last   = 1'b0;
            beat_q.push_back(r);
        endfunction

        function void store_frame(logic [TAG_W-1:0] tag);
            store[(head + fill) % DEPTH] = tag;
            fill++;
        endfunction

        // release oldest held frames until only `keep` remain
        function void drain_to(int unsigned keep, logic speech);
            while (fill > keep) begin
                release_frame(store[head], speech);
                head = (head + 1) % DEPTH;
                fill--;
            end
        endfunction

        function int unsigned margin_depth();
            return (lead_frames > DEPTH - 1) ? DEPTH - 1 : lead_frames;
        endfunction

        function void onset_frame(logic [TAG_W-1:0] tag, logic sp);
            store_frame(tag);
            if (!sp) begin
                // burst too short: everything but the margin goes out as silence
                drain_to(margin_depth(), 1'b0);
                state = ST_SILENCE;
                return;
            end
            if (burst_len < 63) burst_len++;
            if (burst_len >= burst_min) begin
                drain_to(0, 1'b1);
                state = ST_SPEECH;
            end else if (fill >= DEPTH) begin
                // store full with the burst still unconfirmed
                drain_to(DEPTH - 1, 1'b0);
            end
        endfunction

        function void hangover_frame(logic [TAG_W-1:0] tag, logic sp);
            if (!sp) begin
                if (hang_frames == 0) begin
                    release_frame(tag, 1'b0);
                    state = ST_SILENCE;
                end else begin
                    if (trail_len < 255) trail_len++;
                    drain_to(0, 1'b1);
                    release_frame(tag, 1'b1);
                    if (trail_len >= hang_frames) state = ST_SILENCE;
                end
            end else begin
                // new burst after hangover always goes through the onset check
                drain_to(0, 1'b1);
                state     = ST_ONSET_CHECK;
                burst_len = 0;
                onset_frame(tag, sp);
            end
        endfunction

        function void speech_frame(logic [TAG_W-1:0] tag, logic sp);
            if (!sp) begin
                state     = ST_HANGOVER;
                trail_len = 0;
                hangover_frame(tag, sp);
            end else begin
                drain_to(0, 1'b1);
                release_frame(tag, 1'b1);
            end
        endfunction

        function void silence_frame(logic [TAG_W-1:0] tag, logic sp);
            if (!sp) begin
                store_frame(tag);
                drain_to(margin_depth(), 1'b0);
            end else if (burst_min > 0) begin
                state     = ST_ONSET_CHECK;
                burst_len = 0;
                onset_frame(tag, sp);
            end else begin
                state = ST_SPEECH;
                speech_frame(tag, sp);
            end
        endfunction

        function void note_beat(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag, logic sp);
            t_frame_result r;
            beat_q.delete();
            beats_noted++;
            case (mode)
                MODE_FRAME: begin
                    case (state)
                        ST_SILENCE:     silence_frame(tag, sp);
                        ST_ONSET_CHECK: onset_frame(tag, sp);
                        ST_SPEECH:      speech_frame(tag, sp);
                        default:        hangover_frame(tag, sp);
                    endcase
                end
                MODE_FLUSH, MODE_FLUSH_SIL: begin
                    drain_to(0, (state == ST_SPEECH) || (state == ST_HANGOVER));
                    if (mode == MODE_FLUSH_SIL) begin
                        state     = ST_SILENCE;
                        burst_len = 0;
                        trail_len = 0;
                    end
                end
                default: ignored++;
            endcase
            for (int i = 0; i < beat_q.size(); i++) begin
                r      = beat_q[i];
                r.last = (i == beat_q.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic [TAG_W-1:0] tag, logic speech, logic last);
            t_frame_result want;
            results_seen++;
            if (speech === 1'b1) speech_out++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: tag %h speech %b last %b",
                             results_seen, tag, speech, last);
                return;
            end
            want = expected_q.pop_front();
            if (want.tag !== tag || want.speech !== speech || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at result %0d: expected tag %h speech %b last %b, ",
                              "got tag %h speech %b last %b"},
                             results_seen, want.tag, want.speech, want.last,
                             tag, speech, last);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vfls_in_if  #(.TAG_BITS(TAG_W)) in_ch ();
    vfls_out_if #(.TAG_BITS(TAG_W)) out_ch ();

    vad_frame_label_smoother_unit #(
        .HOLD_DEPTH (DEPTH),
        .TAG_BITS   (TAG_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    label_scoreboard sb = new();

    // current register values, used to shape the random runs
    int unsigned cur_lm;
    int unsigned cur_ms;
    int unsigned cur_rm;
    int unsigned settings_applied = 0;

    // steady = no idling on that side for a while
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned stall_left = 0;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Monitor: both channels are sampled at the rising edge, before the block
    // updates. Results are checked before the input beat of the same edge is
    // noted, since a beat cannot cause a result at the edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_frame_tag, out_ch.out_is_speech, out_ch.last);
            if (in_ch.valid && in_ch.ready)
                sb.note_beat(in_ch.mode, in_ch.frame_tag, in_ch.is_speech);
        end
    end

    // Result sink: random back-pressure, changed at the falling edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                if (!rx_steady) stall_left = idle_len();
            end
        end
    end

    // Watchdog: generous bound on the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks; all start and end at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                             input logic sp);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.mode      = mode;
        in_ch.frame_tag = tag;
        in_ch.is_speech = sp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic sp);
        send_beat(MODE_FRAME, TAG_W'($urandom), sp);
    endtask

    // hold the sender until every expected result is out, then let the
    // block finish any beat that releases nothing
    task automatic quiesce(input int unsigned settle);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input int unsigned lm, input int unsigned ms,
                                  input int unsigned rm);
        quiesce(SETTLE_CYCLES);
        write_reg(CFG_LEAD_FRAMES, CFG_DATA_W'(lm));
        write_reg(CFG_BURST_MIN, CFG_DATA_W'(ms));
        write_reg(CFG_HANG_FRAMES, CFG_DATA_W'(rm));
        cur_lm = lm;
        cur_ms = ms;
        cur_rm = rm;
        settings_applied++;
    endtask

    // Random traffic: mostly silence and speech runs sized around the current
    // margins and burst length, plus lone frames, flushes and reserved-mode noise.
    task automatic run_random_phase(input int unsigned n_frames);
        int unsigned sent;
        int unsigned run_len;
        int unsigned pause_at;
        int unsigned pick;
        bit          paused;
        sent      = 0;
        paused    = 1'b0;
        pause_at  = $urandom_range(n_frames / 4, 3 * n_frames / 4);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        while (sent < n_frames) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_beat(($urandom_range(0, 1) != 0) ? MODE_FLUSH : MODE_FLUSH_SIL,
                          TAG_W'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 7) begin
                send_beat(MODE_RESERVED, TAG_W'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick < 17) begin
                send_frame(1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 58) begin
                // silence: either around the left margin or around the hangover length,
                // capped at 40 frames
                if ($urandom_range(0, 2) == 0)
                    run_len = $urandom_range(1, (cur_rm > 36) ? 40 : cur_rm + 4);
                else
                    run_len = $urandom_range(1, cur_lm + 4);
                repeat (run_len) send_frame(1'b0);
                sent += run_len;
            end else begin
                // speech burst just short of, at, or past the minimum length
                run_len = $urandom_range(1, cur_ms + 3);
                repeat (run_len) send_frame(1'b1);
                sent += run_len;
            end
            if (!paused && sent >= pause_at) begin
                quiesce(0);
                paused = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LEAD_FRAMES;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_FRAME;
        in_ch.frame_tag = '0;
        in_ch.is_speech = 1'b0;
        cur_lm          = 0;
        cur_ms          = 0;
        cur_rm          = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset register values: onset with no burst check, then
        // silence after speech with no hangover. Tag extremes go in here.
        send_beat(MODE_FRAME, {TAG_W{1'b0}}, 1'b1);
        send_beat(MODE_FRAME, {TAG_W{1'b1}}, 1'b0);

        // Directed walk through every phase with small margins.
        apply_settings(3, 3, 2);
        repeat (4) send_frame(1'b0);        // left margin fills, oldest goes out
        send_frame(1'b1);                   // short burst ...
        send_frame(1'b0);                   // ... relabelled silence
        repeat (3) send_frame(1'b1);        // confirmed burst, margin becomes speech
        send_frame(1'b1);                   // steady speech
        send_frame(1'b0);                   // hangover starts
        send_frame(1'b1);                   // burst after hangover: onset check again
        repeat (2) send_frame(1'b1);        // confirmed
        repeat (3) send_frame(1'b0);        // hangover runs out, back to silence
        send_beat(MODE_RESERVED, TAG_W'($urandom), 1'b1);
        send_frame(1'b1);
        send_beat(MODE_FLUSH, TAG_W'($urandom), 1'b1);     // flush during onset check
        repeat (2) send_frame(1'b1);                       // burst count carried over
        send_frame(1'b0);
        send_beat(MODE_FLUSH_SIL, TAG_W'($urandom), 1'b0); // flush during hangover
        quiesce(0);

        // Random phases over a spread of settings, extremes included. A
        // minimum burst of 63 lets an unconfirmed burst fill the whole store.
        apply_settings(0, 0, 0);     run_random_phase(55);
        apply_settings(31, 32, 255); run_random_phase(55);
        apply_settings(5, 1, 3);     run_random_phase(55);
        apply_settings(31, 63, 1);   run_random_phase(55);
        apply_settings(2, 0, 0);     run_random_phase(50);
        apply_settings(10, 8, 20);   run_random_phase(55);
        apply_settings($urandom_range(0, 31), $urandom_range(0, 32), $urandom_range(0, 255));
        run_random_phase(55);

        quiesce(SETTLE_CYCLES);

        $display("Run covered %0d input beats (%0d reserved-mode) and %0d results, %0d speech,",
                 sb.beats_noted, sb.ignored, sb.results_seen, sb.speech_out);
        $display("across %0d register settings with random idling on both channels; %0d mismatches.",
                 settings_applied, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
